[sv/sfpid_pkg.sv]
// shared constants and codes for the single-axis force pid block
package sfpid_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned AXIS_W  = 2;

  // shared multiplier operand and product widths
  localparam int unsigned OP_W   = 33;
  localparam int unsigned PROD_W = 2 * OP_W;

  // integral is held within [-1.0, 1.0] in q16.16, so 18 signed bits
  localparam int unsigned INTEG_W = 18;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd5;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // 0.01 in q0.32, derivative scale, integral limit
  localparam logic signed [OP_W-1:0] INTEG_STEP  = 33'sd42949673;
  localparam logic signed [OP_W-1:0] DERIV_SCALE = 33'sd100;
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 18'sd65536;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = -18'sd65536;

  // register reset values
  localparam logic [DATA_W-1:0] KP_RESET = 32'd16777;
  localparam logic [DATA_W-1:0] KI_RESET = 32'd1678;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh80000000;

endpackage

[sv/sfpid_in_if.sv]
// input channel: one control tick with measured forces and flags
interface sfpid_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sfpid_pkg::DATA_W-1:0]  force_x;
  logic signed [sfpid_pkg::DATA_W-1:0]  force_y;
  logic signed [sfpid_pkg::DATA_W-1:0]  force_z;
  logic                                 reading_valid;
  logic                                 restart;

  modport source (output valid, force_x, force_y, force_z, reading_valid, restart,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, reading_valid, restart,
                output ready);
endinterface

[sv/sfpid_out_if.sv]
// result channel: velocity command on three axes and the force error
interface sfpid_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sfpid_pkg::DATA_W-1:0]  vel_x;
  logic signed [sfpid_pkg::DATA_W-1:0]  vel_y;
  logic signed [sfpid_pkg::DATA_W-1:0]  vel_z;
  logic signed [sfpid_pkg::DATA_W-1:0]  error_out;

  modport source (output valid, vel_x, vel_y, vel_z, error_out, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, error_out, output ready);
endinterface

[sv/sfpid_mul.sv]
// shared signed multiplier with registered product
module sfpid_mul (
  input  logic                                  clk,
  input  logic signed [sfpid_pkg::OP_W-1:0]     op_a,
  input  logic signed [sfpid_pkg::OP_W-1:0]     op_b,
  output logic signed [sfpid_pkg::PROD_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[sv/single_axis_force_pid.sv]
// single-axis force pid controller top level
// usage:
//   in_ch carries one control tick: forces on x, y, z (q16.16), a reading
//   flag and a restart flag. in_ch.ready is high only while the sequencer
//   is idle. out_ch carries the velocity command on the controlled axis
//   (other axes zero) and the force error, one beat per run with an axis.
//   cfg_we/cfg_idx/cfg_data write the six control registers; write them
//   only while the block is idle.
// timing:
//   one 33x33 multiplier is shared by the five products of a tick, which
//   are formed in turn; in_ch.ready returns in the same cycle that the
//   result is loaded. a tick that is disabled or has no reading only
//   applies restart.
// reset:
//   rst_n clears integral, previous error and the registers to defaults,
//   and drops out_ch.valid.
// stall:
//   a result waits in the output register while out_ch.ready is low; a
//   new tick may be accepted meanwhile, but its result holds in the final
//   step until the earlier beat is taken.
module single_axis_force_pid (
  input  logic                                  clk,
  input  logic                                  rst_n,
  sfpid_in_if.sink                              in_ch,
  sfpid_out_if.source                           out_ch,
  input  logic                                  cfg_we,
  input  logic [sfpid_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [sfpid_pkg::DATA_W-1:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_M_STEP,
    S_M_DIFF,
    S_M_P,
    S_M_I,
    S_M_D,
    S_ACC,
    S_RND
  } state_t;

  localparam logic signed [sfpid_pkg::PROD_W-1:0] PROD_W_ONE = 1;

  state_t state_r;

  // configuration
  logic                                 enable_r;
  logic [sfpid_pkg::AXIS_W-1:0]         axis_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  target_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  kp_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  ki_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  kd_r;

  // controller state
  logic signed [sfpid_pkg::INTEG_W-1:0] integ_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  prev_r;

  // per-tick working registers
  logic signed [sfpid_pkg::DATA_W-1:0]  force_sel_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  err_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  deriv_r;
  logic signed [sfpid_pkg::PROD_W-1:0]  acc_r;

  // output beat
  logic                                 out_valid_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  vel_x_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  vel_y_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  vel_z_r;
  logic signed [sfpid_pkg::DATA_W-1:0]  err_out_r;

  logic signed [sfpid_pkg::OP_W-1:0]    op_a;
  logic signed [sfpid_pkg::OP_W-1:0]    op_b;
  logic signed [sfpid_pkg::PROD_W-1:0]  prod_r;

  logic                                 in_acc;
  logic                                 out_free;
  logic signed [sfpid_pkg::DATA_W-1:0]  force_pick;
  logic signed [sfpid_pkg::DATA_W:0]    err_wide;
  logic signed [sfpid_pkg::DATA_W-1:0]  err_sat;
  logic signed [sfpid_pkg::PROD_W-1:0]  step_rnd;
  logic signed [sfpid_pkg::PROD_W-33:0] step_q;
  logic signed [sfpid_pkg::PROD_W-32:0] integ_sum;
  logic signed [sfpid_pkg::INTEG_W-1:0] integ_clamp;
  logic signed [sfpid_pkg::DATA_W-1:0]  deriv_sat;
  logic signed [sfpid_pkg::PROD_W-1:0]  cmd_rnd;
  logic signed [sfpid_pkg::DATA_W-1:0]  cmd_sat;

  sfpid_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.vel_x     = vel_x_r;
  assign out_ch.vel_y     = vel_y_r;
  assign out_ch.vel_z     = vel_z_r;
  assign out_ch.error_out = err_out_r;

  always_comb begin
    unique case (axis_r)
      sfpid_pkg::AXIS_Y: force_pick = in_ch.force_y;
      sfpid_pkg::AXIS_Z: force_pick = in_ch.force_z;
      default:           force_pick = in_ch.force_x;
    endcase
  end

  // error = target - force, saturated to 32 bits
  always_comb begin
    err_wide = {target_r[sfpid_pkg::DATA_W-1], target_r}
             - {force_sel_r[sfpid_pkg::DATA_W-1], force_sel_r};
    if (err_wide[sfpid_pkg::DATA_W] != err_wide[sfpid_pkg::DATA_W-1]) begin
      err_sat = err_wide[sfpid_pkg::DATA_W] ? sfpid_pkg::SAT_MIN : sfpid_pkg::SAT_MAX;
    end else begin
      err_sat = err_wide[sfpid_pkg::DATA_W-1:0];
    end
  end

  // integral step rounded half up, then clamp
  always_comb begin
    step_rnd  = prod_r + (PROD_W_ONE <<< 31);
    step_q    = step_rnd[sfpid_pkg::PROD_W-1:32];
    integ_sum = {{(sfpid_pkg::PROD_W-31-sfpid_pkg::INTEG_W){integ_r[sfpid_pkg::INTEG_W-1]}},
                 integ_r}
              + {step_q[sfpid_pkg::PROD_W-33], step_q};
    if (integ_sum > (sfpid_pkg::PROD_W-31)'(sfpid_pkg::INTEG_MAX)) begin
      integ_clamp = sfpid_pkg::INTEG_MAX;
    end else if (integ_sum < (sfpid_pkg::PROD_W-31)'(sfpid_pkg::INTEG_MIN)) begin
      integ_clamp = sfpid_pkg::INTEG_MIN;
    end else begin
      integ_clamp = integ_sum[sfpid_pkg::INTEG_W-1:0];
    end
  end

  // derivative saturation straight off the product
  always_comb begin
    if ((&prod_r[sfpid_pkg::PROD_W-1:31]) || !(|prod_r[sfpid_pkg::PROD_W-1:31])) begin
      deriv_sat = prod_r[sfpid_pkg::DATA_W-1:0];
    end else begin
      deriv_sat = prod_r[sfpid_pkg::PROD_W-1] ? sfpid_pkg::SAT_MIN : sfpid_pkg::SAT_MAX;
    end
  end

  // q26.40 sum to q16.16, round half up and saturate
  always_comb begin
    cmd_rnd = acc_r + (PROD_W_ONE <<< 23);
    if ((&cmd_rnd[sfpid_pkg::PROD_W-1:55]) || !(|cmd_rnd[sfpid_pkg::PROD_W-1:55])) begin
      cmd_sat = cmd_rnd[55:24];
    end else begin
      cmd_sat = cmd_rnd[sfpid_pkg::PROD_W-1] ? sfpid_pkg::SAT_MIN : sfpid_pkg::SAT_MAX;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_M_STEP: begin
        op_a = {err_r[sfpid_pkg::DATA_W-1], err_r};
        op_b = sfpid_pkg::INTEG_STEP;
      end
      S_M_DIFF: begin
        op_a = {err_r[sfpid_pkg::DATA_W-1], err_r} - {prev_r[sfpid_pkg::DATA_W-1], prev_r};
        op_b = sfpid_pkg::DERIV_SCALE;
      end
      S_M_P: begin
        op_a = {kp_r[sfpid_pkg::DATA_W-1], kp_r};
        op_b = {err_r[sfpid_pkg::DATA_W-1], err_r};
      end
      S_M_I: begin
        op_a = {ki_r[sfpid_pkg::DATA_W-1], ki_r};
        op_b = {{(sfpid_pkg::OP_W-sfpid_pkg::INTEG_W){integ_r[sfpid_pkg::INTEG_W-1]}},
                integ_r};
      end
      S_M_D: begin
        op_a = {kd_r[sfpid_pkg::DATA_W-1], kd_r};
        op_b = {deriv_r[sfpid_pkg::DATA_W-1], deriv_r};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      axis_r      <= sfpid_pkg::AXIS_Z;
      target_r    <= '0;
      kp_r        <= sfpid_pkg::KP_RESET;
      ki_r        <= sfpid_pkg::KI_RESET;
      kd_r        <= '0;
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          sfpid_pkg::REG_ENABLE: enable_r <= cfg_data[0];
          sfpid_pkg::REG_AXIS:   axis_r   <= cfg_data[sfpid_pkg::AXIS_W-1:0];
          sfpid_pkg::REG_TARGET: target_r <= cfg_data;
          sfpid_pkg::REG_KP:     kp_r     <= cfg_data;
          sfpid_pkg::REG_KI:     ki_r     <= cfg_data;
          sfpid_pkg::REG_KD:     kd_r     <= cfg_data;
          default: ;
        endcase
      end

      // the rounding step sets valid itself when it loads a beat
      if (out_valid_r && out_ch.ready && (state_r != S_RND)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.restart) begin
              integ_r <= '0;
              prev_r  <= '0;
            end
            force_sel_r <= force_pick;
            if (enable_r && in_ch.reading_valid) begin
              state_r <= S_ERR;
            end
          end
        end
        S_ERR: begin
          err_r   <= err_sat;
          state_r <= S_M_STEP;
        end
        S_M_STEP: begin
          state_r <= S_M_DIFF;
        end
        S_M_DIFF: begin
          integ_r <= integ_clamp;
          state_r <= S_M_P;
        end
        S_M_P: begin
          deriv_r <= deriv_sat;
          prev_r  <= err_r;
          // axis code with no axis: state moves, no beat
          state_r <= (axis_r == sfpid_pkg::AXIS_NONE) ? S_IDLE : S_M_I;
        end
        S_M_I: begin
          acc_r   <= prod_r;
          state_r <= S_M_D;
        end
        S_M_D: begin
          acc_r   <= acc_r + prod_r;
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + prod_r;
          state_r <= S_RND;
        end
        S_RND: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            vel_x_r     <= (axis_r == sfpid_pkg::AXIS_X) ? cmd_sat : '0;
            vel_y_r     <= (axis_r == sfpid_pkg::AXIS_Y) ? cmd_sat : '0;
            vel_z_r     <= (axis_r == sfpid_pkg::AXIS_Z) ? cmd_sat : '0;
            err_out_r   <= err_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= sfpid_pkg::INTEG_MAX) && (integ_r >= sfpid_pkg::INTEG_MIN))
    else $error("integral outside clamp range");

  a_beat_from_round: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RND))
    else $error("output beat raised outside the rounding step");

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && enable_r && in_ch.reading_valid) |=> (state_r == S_ERR))
    else $error("enabled tick with a reading did not start the sequence");

  a_skip_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !(enable_r && in_ch.reading_valid)) |=> (state_r == S_IDLE))
    else $error("tick without control left the idle state");
`endif

endmodule
